>>> rtl/core/srtf_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SRTF_SCHEDULER_MACROS_SVH
`define SRTF_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge of clk while rst_n is high.
`define SRTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define SRTF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRTF_ASSERT(lbl, prop, msg)
`define SRTF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/srtf_pkg.sv
// Shared types and constants for the SRTF scheduler.
// Used by the sequencer and the top level; no dependencies.
package srtf_pkg;

  localparam int IDX_W      = 4;
  localparam int BURST_W    = 16;
  localparam int OUT_TIME_W = 20;
  localparam int CNT_W      = 5;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // One table entry as held in the entry RAM.
  typedef struct packed {
    logic [BURST_W-1:0] rem;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] arr;
  } entry_t;

  // Datapath controls issued by the sequencer each cycle.
  typedef struct packed {
    logic in_ready;
    logic ld_write;
    logic scan;
    logic cmp;
    logic update;
    logic finish;
    logic push;
  } ctrl_t;

  // Datapath conditions seen by the sequencer's jump logic.
  typedef struct packed {
    logic item_acc;
    logic is_tick;
    logic more;
    logic out_full;
  } status_t;

endpackage

>>> rtl/core/srtf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/srtf_seq.sv
// Microcoded sequencer: step counter, control ROM and jump logic.
// Depends on srtf_pkg for the control and status structs.
module srtf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  srtf_pkg::status_t status,
  output srtf_pkg::ctrl_t   ctrl
);
  import srtf_pkg::*;

  typedef logic [2:0] upc_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ITEM,
    C_TICK,
    C_MORE,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    upc_t  target;
  } uword_t;

  localparam upc_t UPC_FETCH    = 3'd0;
  localparam upc_t UPC_DISPATCH = 3'd1;
  localparam upc_t UPC_LOAD     = 3'd2;
  localparam upc_t UPC_SCAN     = 3'd3;
  localparam upc_t UPC_DRAIN    = 3'd4;
  localparam upc_t UPC_UPDATE   = 3'd5;
  localparam upc_t UPC_FINISH   = 3'd6;
  localparam upc_t UPC_PUSH     = 3'd7;

  // Control store. The push step is last so that falling through wraps
  // the step counter back to fetch.
  function automatic uword_t rom(input upc_t pc);
    uword_t w;
    begin
      w = '0;
      unique case (pc)
        UPC_FETCH: begin
          w.ctrl.in_ready = 1'b1;
          w.cond          = C_NO_ITEM;
          w.target        = UPC_FETCH;
        end
        UPC_DISPATCH: begin
          w.cond   = C_TICK;
          w.target = UPC_SCAN;
        end
        UPC_LOAD: begin
          w.ctrl.ld_write = 1'b1;
          w.cond          = C_ALWAYS;
          w.target        = UPC_PUSH;
        end
        UPC_SCAN: begin
          w.ctrl.scan = 1'b1;
          w.ctrl.cmp  = 1'b1;
          w.cond      = C_MORE;
          w.target    = UPC_SCAN;
        end
        UPC_DRAIN: begin
          w.ctrl.cmp = 1'b1;
          w.cond     = C_NEXT;
        end
        UPC_UPDATE: begin
          w.ctrl.update = 1'b1;
          w.cond        = C_NEXT;
        end
        UPC_FINISH: begin
          w.ctrl.finish = 1'b1;
          w.cond        = C_NEXT;
        end
        UPC_PUSH: begin
          w.ctrl.push = 1'b1;
          w.cond      = C_OUT_FULL;
          w.target    = UPC_PUSH;
        end
        default: w = '0;
      endcase
      return w;
    end
  endfunction

  upc_t   pc_r;
  upc_t   pc_nxt;
  uword_t uw;
  logic   take;

  assign uw   = rom(pc_r);
  assign ctrl = uw.ctrl;

  always_comb begin
    unique case (uw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_ITEM:  take = !status.item_acc;
      C_TICK:     take = status.is_tick;
      C_MORE:     take = status.more;
      C_OUT_FULL: take = status.out_full;
      default:    take = 1'b0;
    endcase
    pc_nxt = take ? uw.target : pc_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/core/srtf_scheduler.sv
// Shortest-remaining-time-first scheduler. A load item writes one table
// entry and returns an all-zero result. A tick item scans the first
// min(process_count, MAX_PROCS) entries through the entry RAM's single read
// port, one entry per cycle, then updates the winner. One item is worked on
// at a time, and the finished result sits in an output register so the next
// item can be taken while it waits. Entries never loaded read as idle through
// per-entry valid bits cleared at reset, so no clearing pass is needed.
module srtf_scheduler #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srtf_pkg::CNT_W-1:0]        cfg_process_count,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [srtf_pkg::IDX_W-1:0]        in_proc_index,
  input  logic [srtf_pkg::BURST_W-1:0]      in_burst_time,
  input  logic [srtf_pkg::BURST_W-1:0]      in_arrival_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_ran,
  output logic [srtf_pkg::IDX_W-1:0]        out_proc_id,
  output logic                              out_done_res,
  output logic [srtf_pkg::OUT_TIME_W-1:0]   out_completion_time,
  output logic [srtf_pkg::OUT_TIME_W-1:0]   out_waiting_time,
  output logic [srtf_pkg::OUT_TIME_W-1:0]   out_turnaround_time
);
  import srtf_pkg::*;

  `include "srtf_scheduler_macros.svh"

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int EW = $bits(entry_t);

  ctrl_t   ctrl;
  status_t status;

  // Configuration and state
  logic [CNT_W-1:0]     count_r;
  logic [MAX_PROCS-1:0] valid_r;
  logic [TIME_BITS-1:0] time_r;

  // Latched item
  op_t                op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [BURST_W-1:0] burst_in_r;
  logic [BURST_W-1:0] arr_in_r;

  // Scan
  logic [CW-1:0]      scan_cnt_r;
  logic               rd_pend_r;
  logic [AW-1:0]      rd_addr_r;
  logic               found_r;
  logic [AW-1:0]      best_r;
  logic [BURST_W-1:0] best_rem_r;
  logic [BURST_W-1:0] best_burst_r;
  logic [BURST_W-1:0] best_arr_r;

  // Result staging
  logic                 res_ran_r;
  logic [IDX_W-1:0]     res_id_r;
  logic                 res_done_r;
  logic [TIME_BITS-1:0] res_comp_r;
  logic [TIME_BITS-1:0] res_turn_r;
  logic [TIME_BITS-1:0] res_wait_r;

  // Output register
  logic                  out_valid_r;
  logic                  out_ran_r;
  logic [IDX_W-1:0]      out_id_r;
  logic                  out_done_r;
  logic [OUT_TIME_W-1:0] out_comp_r;
  logic [OUT_TIME_W-1:0] out_wait_r;
  logic [OUT_TIME_W-1:0] out_turn_r;

  logic                 item_acc;
  logic [CW-1:0]        limit;
  logic                 rd_issue;
  logic [AW-1:0]        raddr;
  logic [EW-1:0]        rd_data;
  entry_t               rd_entry;
  logic                 cand_ok;
  logic                 ld_ok;
  logic                 ram_we;
  logic [AW-1:0]        waddr;
  entry_t               wentry;
  logic [TIME_BITS-1:0] next_time;
  logic                 out_full;
  logic                 push_go;
  logic                 best_done;
  logic                 times_zero;

  srtf_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl.in_ready;
  assign item_acc  = in_valid && ctrl.in_ready;

  always_comb begin
    if (32'(count_r) > MAX_PROCS) begin
      limit = CW'(MAX_PROCS);
    end else begin
      limit = CW'(count_r);
    end
  end

  assign rd_issue = ctrl.scan && (scan_cnt_r < limit);
  assign raddr    = scan_cnt_r[AW-1:0];
  assign rd_entry = entry_t'(rd_data);

  // Strict less-than keeps the lowest index on a tie.
  assign cand_ok = rd_pend_r && valid_r[rd_addr_r] && (rd_entry.rem != '0) &&
                   (TIME_BITS'(rd_entry.arr) <= time_r) &&
                   (!found_r || (rd_entry.rem < best_rem_r));

  assign ld_ok  = 32'(idx_r) < MAX_PROCS;
  assign ram_we = (ctrl.ld_write && ld_ok) || (ctrl.update && found_r);

  always_comb begin
    if (ctrl.ld_write) begin
      waddr        = AW'(idx_r);
      wentry.rem   = burst_in_r;
      wentry.burst = burst_in_r;
      wentry.arr   = arr_in_r;
    end else begin
      waddr        = best_r;
      wentry.rem   = best_rem_r - 16'd1;
      wentry.burst = best_burst_r;
      wentry.arr   = best_arr_r;
    end
  end

  srtf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (rd_issue),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign next_time = (time_r == '1) ? time_r : time_r + 1'b1;
  assign best_done = found_r && (best_rem_r == 16'd1);
  assign out_full  = out_valid_r && !out_ready;
  assign push_go   = ctrl.push && !out_full;

  assign status.item_acc = item_acc;
  assign status.is_tick  = (op_r == OP_TICK);
  assign status.more     = ({1'b0, scan_cnt_r} + 1'b1) < {1'b0, limit};
  assign status.out_full = out_full;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CNT_RESET;
      valid_r     <= '0;
      time_r      <= '0;
      scan_cnt_r  <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        count_r <= cfg_process_count;
      end
      if (ctrl.ld_write && ld_ok) begin
        valid_r[AW'(idx_r)] <= 1'b1;
      end
      if (item_acc) begin
        scan_cnt_r <= '0;
        rd_pend_r  <= 1'b0;
        found_r    <= 1'b0;
      end
      if (ctrl.scan) begin
        rd_pend_r <= rd_issue;
        if (rd_issue) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
      end else if (ctrl.cmp) begin
        rd_pend_r <= 1'b0;
      end
      if (ctrl.cmp && cand_ok) begin
        found_r <= 1'b1;
      end
      if (ctrl.update) begin
        time_r <= next_time;
      end
      if (push_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (item_acc) begin
      op_r       <= op_t'(in_op);
      idx_r      <= in_proc_index;
      burst_in_r <= in_burst_time;
      arr_in_r   <= in_arrival_time;
    end
    if (rd_issue) begin
      rd_addr_r <= raddr;
    end
    if (ctrl.cmp && cand_ok) begin
      best_r       <= rd_addr_r;
      best_rem_r   <= rd_entry.rem;
      best_burst_r <= rd_entry.burst;
      best_arr_r   <= rd_entry.arr;
    end
    if (ctrl.ld_write) begin
      res_ran_r  <= 1'b0;
      res_id_r   <= '0;
      res_done_r <= 1'b0;
      res_comp_r <= '0;
      res_turn_r <= '0;
      res_wait_r <= '0;
    end
    if (ctrl.update) begin
      res_ran_r  <= found_r;
      res_id_r   <= found_r ? IDX_W'(best_r) : '0;
      res_done_r <= best_done;
      res_comp_r <= best_done ? next_time : '0;
      // The winner arrived no later than the current time, so this cannot wrap.
      res_turn_r <= best_done ? next_time - TIME_BITS'(best_arr_r) : '0;
    end
    if (ctrl.finish) begin
      if (res_done_r && (res_turn_r >= TIME_BITS'(best_burst_r))) begin
        res_wait_r <= res_turn_r - TIME_BITS'(best_burst_r);
      end else begin
        res_wait_r <= '0;
      end
    end
    if (push_go) begin
      out_ran_r  <= res_ran_r;
      out_id_r   <= res_id_r;
      out_done_r <= res_done_r;
      out_comp_r <= OUT_TIME_W'(res_comp_r);
      out_wait_r <= OUT_TIME_W'(res_wait_r);
      out_turn_r <= OUT_TIME_W'(res_turn_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ran             = out_ran_r;
  assign out_proc_id         = out_id_r;
  assign out_done_res        = out_done_r;
  assign out_completion_time = out_comp_r;
  assign out_waiting_time    = out_wait_r;
  assign out_turnaround_time = out_turn_r;

  assign times_zero = (out_completion_time == '0) && (out_waiting_time == '0) &&
                      (out_turnaround_time == '0);

  `SRTF_ASSERT(a_done_implies_ran, out_valid && out_done_res |-> out_ran, "done without ran")
  `SRTF_ASSERT(a_times_zero_unless_done, out_valid && !out_done_res |-> times_zero, "stray times")
  `SRTF_ASSERT(a_time_monotonic, $past(rst_n) |-> time_r >= $past(time_r), "time went backward")
  `SRTF_ASSERT(a_best_is_loaded, found_r |-> valid_r[best_r], "winner is an unloaded entry")
  `SRTF_ASSERT(a_scan_in_range, ctrl.scan |-> scan_cnt_r <= limit, "scan ran past the limit")

endmodule
